// ----- hdl/bsg_pkg.sv -----
`default_nettype none
package bsg_pkg;

  // Timer width for the expiry counter
  localparam int unsigned TIMER_BITS = 16;
  // Width for timeout sums before they are fitted to the timer
  localparam int unsigned CALC_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam logic [CALC_W-1:0] TIMER_MAX_C = CALC_W'((64'd1 << TIMER_BITS) - 64'd1);

  localparam logic [7:0] SYN_SYMBOL = 8'hAA;

  // Queue between classifier and executor
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYN_ENABLE   = 3'd0,
    REG_OWN_ADDRESS  = 3'd1,
    REG_BASE_MS      = 3'd2,
    REG_MARGIN_MS    = 3'd3,
    REG_ADDR_STEP_MS = 3'd4,
    REG_CARRIER_MS   = 3'd5,
    REG_RETRY_MS     = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_BYTE = 1'b1
  } op_t;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
    logic       request_pending;
    logic [7:0] request_address;
  } in_item_t;

  typedef struct packed {
    logic        send_valid;
    logic [7:0]  send_byte;
    logic        syn_generated;
    logic        postponed;
    logic        postpone_wait_valid;
    logic [15:0] postpone_wait_ms;
    logic        bus_request_seen;
  } out_item_t;

  typedef struct packed {
    logic        syn_enable;
    logic [7:0]  own_address;
    logic [11:0] base_ms;
    logic [11:0] margin_ms;
    logic [5:0]  address_step_ms;
    logic [11:0] quiet_need_ms;
    logic [11:0] retry_ms;
  } cfg_t;

  // Classified item as it waits in the queue
  typedef struct packed {
    logic       is_byte;
    logic       rx_is_syn;
    logic       answer_req;
    logic       addr_is_syn;
    logic [7:0] request_address;
  } cls_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Saturate a timeout to the timer width
  function automatic logic [TIMER_BITS-1:0] timer_fit(input logic [CALC_W-1:0] v);
    logic [TIMER_BITS-1:0] res;
    if (v > TIMER_MAX_C) begin
      res = '1;
    end else begin
      res = v[TIMER_BITS-1:0];
    end
    return res;
  endfunction

  function automatic logic [15:0] sat16_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/bus_syn_generator.sv -----
// An accepted item is queued and then moved into the result register.
// Throughput: one item per cycle while out_ready is high; a two-entry queue
// lets the input side keep accepting while a result waits for out_ready.
// Reset: synchronous, active-low rst_n; configuration returns to its defaults,
// the timer is unarmed and quiet time reads saturated.
`default_nettype none
module bus_syn_generator (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  bsg_pkg::in_item_t            in_item,
  output logic                               out_valid,
  input  wire                                out_ready,
  output bsg_pkg::out_item_t                 out_item,
  input  wire                                cfg_wr_en,
  input  wire  [bsg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [bsg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  bsg_pkg::cfg_t      cfg_r, cfg_nxt;
  bsg_pkg::q_stat_t   q_stat;
  bsg_pkg::cls_item_t push_item;
  bsg_pkg::cls_item_t pop_item;
  logic               push;
  logic               pop;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (bsg_pkg::cfg_reg_t'(cfg_index))
        bsg_pkg::REG_SYN_ENABLE:   cfg_nxt.syn_enable      = cfg_wdata[0];
        bsg_pkg::REG_OWN_ADDRESS:  cfg_nxt.own_address     = cfg_wdata[7:0];
        bsg_pkg::REG_BASE_MS:      cfg_nxt.base_ms         = cfg_wdata[11:0];
        bsg_pkg::REG_MARGIN_MS:    cfg_nxt.margin_ms       = cfg_wdata[11:0];
        bsg_pkg::REG_ADDR_STEP_MS: cfg_nxt.address_step_ms = cfg_wdata[5:0];
        bsg_pkg::REG_CARRIER_MS:   cfg_nxt.quiet_need_ms   = cfg_wdata[11:0];
        bsg_pkg::REG_RETRY_MS:     cfg_nxt.retry_ms        = cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.syn_enable      <= 1'b1;
      cfg_r.own_address     <= 8'd0;
      cfg_r.base_ms         <= 12'd40;
      cfg_r.margin_ms       <= 12'd10;
      cfg_r.address_step_ms <= 6'd1;
      cfg_r.quiet_need_ms   <= 12'd5;
      cfg_r.retry_ms        <= 12'd5;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bsg_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  bsg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  bsg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .item      (pop_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // A queued item always reaches the result register once it is free
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_stat.empty && (!out_valid || out_ready)) |=> out_valid)
    else $error("queued item not moved to result register");

  // An item entering an empty pipe passes the queue, then the result register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (push && q_stat.empty && (!out_valid || out_ready)) |=> ##1 out_valid)
    else $error("result latency exceeded");

  // A deferral never coincides with a send
  a_postpone_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.postponed) |->
      (!out_item.send_valid && !out_item.postpone_wait_valid))
    else $error("postponed result also sends");

  // A finished wait is only reported with our own SYN
  a_wait_syn: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.postpone_wait_valid) |->
      (out_item.syn_generated && out_item.send_byte == bsg_pkg::SYN_SYMBOL))
    else $error("wait reported without own SYN");

endmodule
`default_nettype wire

// ----- hdl/bsg_front.sv -----
`default_nettype none
module bsg_front (
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  bsg_pkg::in_item_t  in_item,
  input  wire  bsg_pkg::q_stat_t   q_stat,
  output logic                     push,
  output bsg_pkg::cls_item_t       push_item
);

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  // Classify the item once so the executor sees flags and the request address
  always_comb begin
    push_item.is_byte         = (in_item.op == bsg_pkg::OP_BYTE);
    push_item.rx_is_syn       = (in_item.rx_byte == bsg_pkg::SYN_SYMBOL);
    push_item.answer_req      = (in_item.rx_byte == bsg_pkg::SYN_SYMBOL) &&
                                in_item.request_pending;
    push_item.addr_is_syn     = (in_item.request_address == bsg_pkg::SYN_SYMBOL);
    push_item.request_address = in_item.request_address;
  end

endmodule
`default_nettype wire

// ----- hdl/bsg_queue.sv -----
`default_nettype none
module bsg_queue (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       push,
  input  wire  bsg_pkg::cls_item_t  push_item,
  input  wire                       pop,
  output bsg_pkg::cls_item_t        pop_item,
  output bsg_pkg::q_stat_t          q_stat
);

  bsg_pkg::cls_item_t mem_r [bsg_pkg::Q_DEPTH];

  logic [bsg_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [bsg_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [bsg_pkg::Q_CNT_W-1:0] count_r, count_nxt;

  function automatic logic [bsg_pkg::Q_PTR_W-1:0] ptr_inc(
    input logic [bsg_pkg::Q_PTR_W-1:0] p);
    return (p == bsg_pkg::Q_PTR_W'(bsg_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign q_stat.full  = (count_r == bsg_pkg::Q_CNT_W'(bsg_pkg::Q_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign pop_item     = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/bsg_back.sv -----
`default_nettype none
module bsg_back (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire  bsg_pkg::cfg_t       cfg,
  input  wire  bsg_pkg::q_stat_t    q_stat,
  input  wire  bsg_pkg::cls_item_t  item,
  output logic                      pop,
  output logic                      out_valid,
  input  wire                       out_ready,
  output bsg_pkg::out_item_t        out_item
);

  localparam int unsigned TB = bsg_pkg::TIMER_BITS;
  localparam int unsigned CW = bsg_pkg::CALC_W;

  // Timer and arbitration state
  logic [TB-1:0] tte_r, tte_nxt;
  logic          armed_r, armed_nxt;
  logic [15:0]   quiet_r, quiet_nxt;
  logic          active_r, active_nxt;
  logic          def_open_r, def_open_nxt;
  logic [15:0]   def_age_r, def_age_nxt;
  logic          req_sent_r, req_sent_nxt;

  logic                out_valid_r, out_valid_nxt;
  bsg_pkg::out_item_t  out_item_r, out_item_nxt;

  logic [13:0]   addr_prod;
  logic [CW-1:0] uniq_sum;
  logic [TB-1:0] uniq_to;
  logic [TB-1:0] tte_dec;
  logic [15:0]   quiet_inc;
  logic [15:0]   age_inc;

  assign pop       = !q_stat.empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Unique timeout from the configuration
  assign addr_prod = cfg.own_address * cfg.address_step_ms;
  assign uniq_sum  = CW'(cfg.base_ms) + CW'(addr_prod) + CW'(cfg.margin_ms);
  assign uniq_to   = bsg_pkg::timer_fit(uniq_sum);

  assign quiet_inc = bsg_pkg::sat16_inc(quiet_r);
  assign age_inc   = def_open_r ? bsg_pkg::sat16_inc(def_age_r) : def_age_r;
  assign tte_dec   = (armed_r && tte_r != '0) ? tte_r - 1'b1 : tte_r;

  // Execute one item
  always_comb begin
    tte_nxt      = tte_r;
    armed_nxt    = armed_r;
    quiet_nxt    = quiet_r;
    active_nxt   = active_r;
    def_open_nxt = def_open_r;
    def_age_nxt  = def_age_r;
    req_sent_nxt = req_sent_r;
    out_item_nxt = '0;

    if (!item.is_byte) begin
      quiet_nxt   = quiet_inc;
      def_age_nxt = age_inc;
      tte_nxt     = tte_dec;
      if (cfg.syn_enable) begin
        if (!armed_r) begin
          tte_nxt   = uniq_to;
          armed_nxt = 1'b1;
        end
        if (tte_nxt == '0) begin
          if (quiet_inc < 16'(cfg.quiet_need_ms)) begin
            // Line busy: defer the SYN
            out_item_nxt.postponed = 1'b1;
            if (!def_open_r) begin
              def_open_nxt = 1'b1;
              def_age_nxt  = '0;
            end
            tte_nxt = bsg_pkg::timer_fit(CW'(cfg.retry_ms));
          end else begin
            if (def_open_r) begin
              out_item_nxt.postpone_wait_valid = 1'b1;
              out_item_nxt.postpone_wait_ms    = age_inc;
              def_open_nxt = 1'b0;
              def_age_nxt  = '0;
            end
            active_nxt                 = 1'b1;
            out_item_nxt.send_valid    = 1'b1;
            out_item_nxt.send_byte     = bsg_pkg::SYN_SYMBOL;
            out_item_nxt.syn_generated = 1'b1;
            tte_nxt                    = uniq_to;
          end
        end
      end
    end else begin
      out_item_nxt.bus_request_seen = req_sent_r;
      req_sent_nxt = 1'b0;
      quiet_nxt    = '0;
      armed_nxt    = 1'b1;
      if (active_r && item.rx_is_syn) begin
        tte_nxt = bsg_pkg::timer_fit(CW'(cfg.base_ms));
      end else begin
        active_nxt = 1'b0;
        tte_nxt    = uniq_to;
      end
      // Answer a SYN with our arbitration address
      if (item.answer_req) begin
        out_item_nxt.send_valid = 1'b1;
        out_item_nxt.send_byte  = item.request_address;
        req_sent_nxt            = 1'b1;
        if (!item.addr_is_syn) begin
          active_nxt = 1'b0;
        end
      end
    end
  end

  assign out_valid_nxt = pop ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tte_r       <= '0;
      armed_r     <= 1'b0;
      quiet_r     <= 16'hFFFF;
      active_r    <= 1'b0;
      def_open_r  <= 1'b0;
      def_age_r   <= '0;
      req_sent_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        tte_r      <= tte_nxt;
        armed_r    <= armed_nxt;
        quiet_r    <= quiet_nxt;
        active_r   <= active_nxt;
        def_open_r <= def_open_nxt;
        def_age_r  <= def_age_nxt;
        req_sent_r <= req_sent_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (pop) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
module testbench;
  import bsg_pkg::*;

  localparam longint unsigned TIMER_LIMIT = (64'd1 << TIMER_BITS) - 64'd1;
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG_IDX = 3'd7;
  localparam int HALF_PERIOD = 4;
  localparam int ITEMS_PER_PHASE = 115;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_item;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bus_syn_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the generator state
  cfg_t                  model_cfg;
  logic [TIMER_BITS-1:0] model_expiry;
  logic                  model_armed;
  logic [15:0]           model_quiet;
  logic                  model_gen_active;
  logic                  model_defer_open;
  logic [15:0]           model_defer_age;
  logic                  model_req_sent;

  out_item_t pending_responses[$];
  int        mismatches = 0;
  bit        gaps_on = 1'b1;
  bit        stalls_on = 1'b1;
  int        stall_left = 0;
  bit        valid_state = 1'b0;
  bit        last_was_syn = 1'b0;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [TIMER_BITS-1:0] fit_to_timer(input longint unsigned v);
    return (v > TIMER_LIMIT) ? '1 : TIMER_BITS'(v);
  endfunction

  function automatic logic [15:0] inc_sat16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [TIMER_BITS-1:0] unique_timeout();
    longint unsigned sum;
    sum = longint'(model_cfg.base_ms);
    sum = sum + longint'(model_cfg.own_address) * longint'(model_cfg.address_step_ms);
    sum = sum + longint'(model_cfg.margin_ms);
    return fit_to_timer(sum);
  endfunction

  function automatic cfg_t default_settings();
    cfg_t c;
    c = '{syn_enable: 1'b1, own_address: 8'd0, base_ms: 12'd40, margin_ms: 12'd10,
          address_step_ms: 6'd1, quiet_need_ms: 12'd5, retry_ms: 12'd5};
    return c;
  endfunction

  task automatic reset_model();
    model_cfg        = default_settings();
    model_expiry     = '0;
    model_armed      = 1'b0;
    model_quiet      = 16'hFFFF;
    model_gen_active = 1'b0;
    model_defer_open = 1'b0;
    model_defer_age  = '0;
    model_req_sent   = 1'b0;
  endtask

  function automatic out_item_t predict_response(input in_item_t it);
    out_item_t r;
    r = '0;
    if (it.op == OP_TICK) begin
      model_quiet = inc_sat16(model_quiet);
      if (model_defer_open) model_defer_age = inc_sat16(model_defer_age);
      if (model_armed && model_expiry != '0) model_expiry = model_expiry - 1'b1;
      if (model_cfg.syn_enable) begin
        // a tick while unarmed loads the unique timeout
        if (!model_armed) begin
          model_expiry = unique_timeout();
          model_armed  = 1'b1;
        end
        if (model_expiry == '0) begin
          if (model_quiet < 16'(model_cfg.quiet_need_ms)) begin
            // line was busy too recently: defer the SYN
            r.postponed = 1'b1;
            if (!model_defer_open) begin
              model_defer_open = 1'b1;
              model_defer_age  = '0;
            end
            model_expiry = fit_to_timer(longint'(model_cfg.retry_ms));
          end else begin
            if (model_defer_open) begin
              r.postpone_wait_valid = 1'b1;
              r.postpone_wait_ms    = model_defer_age;
              model_defer_open      = 1'b0;
              model_defer_age       = '0;
            end
            model_gen_active = 1'b1;
            r.send_valid     = 1'b1;
            r.send_byte      = SYN_SYMBOL;
            r.syn_generated  = 1'b1;
            model_expiry     = unique_timeout();
          end
        end
      end
    end else begin
      r.bus_request_seen = model_req_sent;
      model_req_sent = 1'b0;
      model_quiet    = '0;
      model_armed    = 1'b1;
      // own SYN echo restarts the base interval, anything else the unique one
      if (model_gen_active && it.rx_byte == SYN_SYMBOL) begin
        model_expiry = fit_to_timer(longint'(model_cfg.base_ms));
      end else begin
        model_gen_active = 1'b0;
        model_expiry     = unique_timeout();
      end
      // arbitration answer on SYN
      if (it.rx_byte == SYN_SYMBOL && it.request_pending) begin
        r.send_valid   = 1'b1;
        r.send_byte    = it.request_address;
        model_req_sent = 1'b1;
        if (it.request_address != SYN_SYMBOL) model_gen_active = 1'b0;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_responses.size() == 0) begin
        $error("result item with nothing expected: 0x%0h", out_item);
        mismatches++;
      end else begin
        want = pending_responses.pop_front();
        compare_field("send_valid", want.send_valid, out_item.send_valid);
        compare_field("send_byte", want.send_byte, out_item.send_byte);
        compare_field("syn_generated", want.syn_generated, out_item.syn_generated);
        compare_field("postponed", want.postponed, out_item.postponed);
        compare_field("postpone_wait_valid", want.postpone_wait_valid,
                      out_item.postpone_wait_valid);
        compare_field("postpone_wait_ms", want.postpone_wait_ms, out_item.postpone_wait_ms);
        compare_field("bus_request_seen", want.bus_request_seen, out_item.bus_request_seen);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  task automatic set_in_valid(input bit v);
    if (valid_state != v) begin
      in_valid    <= v;
      valid_state = v;
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic in_item_t make_item(input op_t op, input logic [7:0] rx,
                                         input logic req, input logic [7:0] addr);
    in_item_t it;
    it.op              = op;
    it.rx_byte         = rx;
    it.request_pending = req;
    it.request_address = addr;
    return it;
  endfunction

  function automatic in_item_t tick_item();
    return make_item(OP_TICK, 8'($urandom), 1'($urandom), 8'($urandom));
  endfunction

  task automatic send_item(input in_item_t it);
    int        gap;
    out_item_t want;
    gap = pick_gap();
    if (gap > 0) begin
      set_in_valid(1'b0);
      repeat (gap) @(posedge clk);
    end
    set_in_valid(1'b1);
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    want = predict_response(it);
    pending_responses.push_back(want);
    last_was_syn = want.syn_generated;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(tick_item());
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  // Write all registers while the block is drained; upper data bits are junk
  task automatic apply_config(input cfg_t c);
    set_in_valid(1'b0);
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_write(REG_SYN_ENABLE, {11'($urandom), c.syn_enable});
    cfg_write(REG_OWN_ADDRESS, {4'($urandom), c.own_address});
    cfg_write(REG_BASE_MS, c.base_ms);
    cfg_write(REG_MARGIN_MS, c.margin_ms);
    cfg_write(REG_ADDR_STEP_MS, {6'($urandom), c.address_step_ms});
    cfg_write(REG_CARRIER_MS, c.quiet_need_ms);
    cfg_write(REG_RETRY_MS, c.retry_ms);
    cfg_write(UNUSED_REG_IDX, 12'($urandom));
    cfg_wr_en <= 1'b0;
    model_cfg = c;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset timing, carrier-sense deferral and SYN echo on short timeouts
  task automatic test_postpone_and_echo();
    cfg_t c;
    send_ticks(2);
    c = '{syn_enable: 1'b1, own_address: 8'd1, base_ms: 12'd2, margin_ms: 12'd1,
          address_step_ms: 6'd1, quiet_need_ms: 12'd5, retry_ms: 12'd1};
    apply_config(c);
    send_item(make_item(OP_BYTE, 8'h55, 1'b0, 8'h00));
    send_ticks(5);
    send_item(make_item(OP_BYTE, SYN_SYMBOL, 1'b0, 8'hFF));
    send_ticks(5);
  endtask

  // Request answers on SYN and the byte that follows them
  task automatic test_arbitration();
    send_item(make_item(OP_BYTE, SYN_SYMBOL, 1'b1, 8'h00));
    send_item(make_item(OP_BYTE, 8'h55, 1'b0, 8'h00));
    send_item(make_item(OP_BYTE, SYN_SYMBOL, 1'b1, SYN_SYMBOL));
    send_item(make_item(OP_BYTE, SYN_SYMBOL, 1'b1, 8'hFF));
    send_item(make_item(OP_BYTE, 8'hFF, 1'b1, 8'h12));
  endtask

  // Zero timeouts, zero postpone and generation switched off
  task automatic test_zero_timeouts();
    cfg_t c;
    c = '0;
    c.syn_enable = 1'b1;
    apply_config(c);
    send_item(make_item(OP_BYTE, 8'h10, 1'b0, 8'h00));
    send_ticks(2);
    c.quiet_need_ms = 12'd3;
    apply_config(c);
    send_item(make_item(OP_BYTE, 8'h00, 1'b1, 8'h5A));
    send_ticks(4);
    c = default_settings();
    c.syn_enable = 1'b0;
    apply_config(c);
    send_ticks(2);
    send_item(make_item(OP_BYTE, SYN_SYMBOL, 1'b1, 8'hA5));
  endtask

  // Every register at its maximum; nothing expires but the sums must not wrap
  task automatic test_extreme_settings();
    cfg_t c;
    c = '1;
    apply_config(c);
    send_item(make_item(OP_BYTE, SYN_SYMBOL, 1'b0, 8'h00));
    send_ticks(2);
  endtask

  function automatic cfg_t random_settings();
    cfg_t c;
    c.syn_enable = ($urandom_range(0, 99) < 85);
    c.base_ms = 12'($urandom_range(0, 15));
    c.margin_ms = 12'($urandom_range(0, 6));
    if ($urandom_range(0, 9) == 0) begin
      c.own_address     = 8'($urandom_range(0, 255));
      c.address_step_ms = '0;
    end else begin
      c.own_address     = 8'($urandom_range(0, 7));
      c.address_step_ms = 6'($urandom_range(0, 3));
    end
    c.quiet_need_ms = 12'($urandom_range(0, 8));
    c.retry_ms = 12'($urandom_range(0, 5));
    return c;
  endfunction

  // Mostly ticks, bus bytes with SYN common, own SYNs usually echoed back
  task automatic run_traffic_phase(input int count);
    int         byte_pct;
    logic [7:0] rx;
    logic [7:0] addr;
    byte_pct = $urandom_range(10, 40);
    for (int n = 0; n < count; n++) begin
      addr = ($urandom_range(0, 4) == 0) ? SYN_SYMBOL : 8'($urandom);
      if (last_was_syn && $urandom_range(0, 9) < 7) begin
        send_item(make_item(OP_BYTE, SYN_SYMBOL, 1'($urandom), addr));
      end else if ($urandom_range(0, 99) < byte_pct) begin
        rx = ($urandom_range(0, 9) < 4) ? SYN_SYMBOL : 8'($urandom);
        send_item(make_item(OP_BYTE, rx, 1'($urandom), addr));
      end else begin
        send_item(tick_item());
      end
    end
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 6; p++) begin
      apply_config(random_settings());
      // one phase runs back to back on both sides
      gaps_on   = (p != 4);
      stalls_on = (p != 4);
      run_traffic_phase(ITEMS_PER_PHASE);
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    reset_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_postpone_and_echo();
    test_arbitration();
    test_zero_timeouts();
    test_extreme_settings();
    test_random_traffic();

    // drain
    set_in_valid(1'b0);
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0 && pending_responses.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/bsg_pkg.sv
hdl/bsg_front.sv
hdl/bsg_queue.sv
hdl/bsg_back.sv
hdl/bus_syn_generator.sv
tb/sv/testbench.sv
